/* hdl/q16_fixed_point_alu_macros.svh */
// Assertion macros for the Q16.16 arithmetic unit checker.
// Used by q16_alu_checker.sv; no other dependencies.
`ifndef Q16_FIXED_POINT_ALU_MACROS_SVH
`define Q16_FIXED_POINT_ALU_MACROS_SVH

// Implication that is checked only outside reset.
`define Q16_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("q16 check failed");

// Next-cycle implication that is checked only outside reset.
`define Q16_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("q16 check failed");

// Property that is checked at every edge, reset included.
`define Q16_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("q16 check failed");

`endif

/* hdl/q16_pkg.sv */
// Shared types and constants of the Q16.16 arithmetic unit.
// Has no dependencies; every other file of the block but the macro header uses it.
`timescale 1ns / 1ps

package q16_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned ROOT_STEPS = 10;
  localparam int unsigned NUM_W      = WORD_W + FRAC_BITS;
  localparam int unsigned CNT_W      = $clog2(NUM_W);
  localparam int unsigned STEP_W     = $clog2(ROOT_STEPS + 1);
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);

  // Command codes as they arrive on the input word.
  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_SQRT = 3'd4;
  localparam logic [2:0] CMD_DIST = 3'd5;

  // Internal job kinds after classification.
  typedef enum logic [2:0] {
    OP_NONE, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_DIVZ, OP_SQRT, OP_DIST
  } op_e;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [WORD_W-1:0] opa;
    logic [WORD_W-1:0] opb;
    logic [WORD_W-1:0] opc;
    logic [WORD_W-1:0] opd;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              zero_divide;
  } out_word_t;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } job_t;

endpackage

/* hdl/q16_front.sv */
// Front end: accepts input words, classifies the command and forms point deltas.
// Depends on q16_pkg.
`timescale 1ns / 1ps

module q16_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  q16_pkg::in_word_t in_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output q16_pkg::job_t     job_o
);

  logic          valid_q;
  q16_pkg::job_t job_q, job_d;
  logic          take;

  assign full_o = valid_q && !job_ready_i;
  assign take   = push_i && !full_o;

  always_comb begin
    job_d.a  = in_i.opa;
    job_d.b  = in_i.opb;
    job_d.op = q16_pkg::OP_NONE;
    unique case (in_i.cmd)
      q16_pkg::CMD_ADD:  job_d.op = q16_pkg::OP_ADD;
      q16_pkg::CMD_SUB:  job_d.op = q16_pkg::OP_SUB;
      q16_pkg::CMD_MUL:  job_d.op = q16_pkg::OP_MUL;
      q16_pkg::CMD_DIV: begin
        job_d.op = (in_i.opb == '0) ? q16_pkg::OP_DIVZ : q16_pkg::OP_DIV;
      end
      q16_pkg::CMD_SQRT: job_d.op = q16_pkg::OP_SQRT;
      q16_pkg::CMD_DIST: begin
        job_d.op = q16_pkg::OP_DIST;
        job_d.a  = in_i.opa - in_i.opc;
        job_d.b  = in_i.opb - in_i.opd;
      end
      default:           job_d.op = q16_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (job_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

/* hdl/q16_fifo.sv */
// Short job queue between the front end and the execution back end.
// Depends on q16_pkg.
`timescale 1ns / 1ps

module q16_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  output logic          wr_ready_o,
  input  q16_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_i,
  output q16_pkg::job_t rd_data_o
);

  q16_pkg::job_t                 mem_q [q16_pkg::QDEPTH];
  logic [q16_pkg::QPTR_W-1:0]    wptr_q, rptr_q;
  logic [q16_pkg::QPTR_W:0]      cnt_q;
  logic                          do_wr, do_rd;

  assign wr_ready_o = cnt_q != (q16_pkg::QPTR_W+1)'(q16_pkg::QDEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign do_wr      = wr_i && wr_ready_o;
  assign do_rd      = rd_i && rd_valid_o;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

/* hdl/q16_back.sv */
// Execution back end: multiplier, bit-serial divider and Newton root sequencer.
// Depends on q16_pkg.
`timescale 1ns / 1ps

module q16_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_pop_o,
  input  q16_pkg::job_t      job_i,
  output logic               empty_o,
  input  logic               pop_i,
  output q16_pkg::out_word_t out_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL    = 8'b0000_0010,
    S_DY     = 8'b0000_0100,
    S_DSUM   = 8'b0000_1000,
    S_RSTART = 8'b0001_0000,
    S_RSTEP  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  localparam int unsigned W = q16_pkg::WORD_W;

  state_e                       st_q, st_d;
  logic signed [2*W-1:0]        prod, prod_q;
  logic [W-1:0]                 mul_a, mul_b;
  logic [W-1:0]                 dy_q, sum_q, arg_q, x_q, dvsr_q;
  logic [q16_pkg::NUM_W-1:0]    num_q, quo_q, quo_nx;
  logic [W:0]                   rem_q, rem_sh, rem_nx;
  logic [q16_pkg::CNT_W-1:0]    cnt_q;
  logic [q16_pkg::STEP_W-1:0]   step_q;
  logic                         root_q, ge, last;
  logic [W-1:0]                 xsum;
  q16_pkg::out_word_t           res_q, out_q;
  logic                         out_v_q, load_out;

  assign mul_a = (st_q == S_IDLE) ? job_i.a : dy_q;
  assign mul_b = (st_q == S_IDLE) ?
                 ((job_i.op == q16_pkg::OP_DIST) ? job_i.a : job_i.b) : dy_q;
  assign prod  = $signed(mul_a) * $signed(mul_b);

  // One restoring division step per cycle.
  assign rem_sh = {rem_q[W-1:0], num_q[q16_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvsr_q};
  assign rem_nx = ge ? rem_sh - {1'b0, dvsr_q} : rem_sh;
  assign quo_nx = {quo_q[q16_pkg::NUM_W-2:0], ge};
  assign last   = cnt_q == q16_pkg::CNT_W'(q16_pkg::NUM_W - 1);
  assign xsum   = x_q + quo_nx[W-1:0];

  assign job_pop_o = (st_q == S_IDLE) && job_valid_i;
  assign load_out  = (st_q == S_OUT) && (!out_v_q || pop_i);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.op)
            q16_pkg::OP_MUL:  st_d = S_MUL;
            q16_pkg::OP_DIV:  st_d = S_DIV;
            q16_pkg::OP_SQRT: st_d = S_RSTART;
            q16_pkg::OP_DIST: st_d = S_DY;
            default:          st_d = S_OUT;
          endcase
        end
      end
      S_MUL:    st_d = S_OUT;
      S_DY:     st_d = S_DSUM;
      S_DSUM:   st_d = S_RSTART;
      S_RSTART: st_d = (arg_q < W'(2)) ? S_OUT : S_RSTEP;
      S_RSTEP: begin
        if (step_q == q16_pkg::STEP_W'(q16_pkg::ROOT_STEPS)) begin
          st_d = S_OUT;
        end else if (x_q != '0) begin
          st_d = S_DIV;
        end
      end
      S_DIV:    if (last) st_d = root_q ? S_RSTEP : S_OUT;
      S_OUT:    if (load_out) st_d = S_IDLE;
      default:  st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (load_out) out_q <= res_q;
    unique case (st_q)
      S_IDLE: begin
        res_q.zero_divide <= (job_i.op == q16_pkg::OP_DIVZ);
        root_q            <= 1'b0;
        dy_q              <= job_i.b;
        arg_q             <= job_i.a;
        num_q             <= {job_i.a, q16_pkg::FRAC_BITS'(0)};
        dvsr_q            <= job_i.b;
        rem_q             <= '0;
        cnt_q             <= '0;
        case (job_i.op)
          q16_pkg::OP_ADD:  res_q.value <= job_i.a + job_i.b;
          q16_pkg::OP_SUB:  res_q.value <= job_i.a - job_i.b;
          q16_pkg::OP_DIVZ: res_q.value <= '1;
          default:          res_q.value <= '0;
        endcase
      end
      S_MUL:  res_q.value <= prod_q[q16_pkg::FRAC_BITS +: W];
      S_DY:   sum_q <= prod_q[q16_pkg::FRAC_BITS +: W];
      S_DSUM: arg_q <= sum_q + prod_q[q16_pkg::FRAC_BITS +: W];
      S_RSTART: begin
        res_q.value <= '0;
        x_q         <= arg_q >> 1;
        step_q      <= '0;
      end
      S_RSTEP: begin
        res_q.value <= x_q;
        root_q      <= 1'b1;
        num_q       <= {arg_q, q16_pkg::FRAC_BITS'(0)};
        dvsr_q      <= x_q;
        rem_q       <= '0;
        cnt_q       <= '0;
        // A zero estimate takes an all-ones quotient without dividing.
        if (x_q == '0 && step_q != q16_pkg::STEP_W'(q16_pkg::ROOT_STEPS)) begin
          x_q    <= {1'b0, {(W-1){1'b1}}};
          step_q <= step_q + 1'b1;
        end
      end
      S_DIV: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        num_q <= {num_q[q16_pkg::NUM_W-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          res_q.value <= quo_nx[W-1:0];
          if (root_q) begin
            x_q    <= xsum >> 1;
            step_q <= step_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign empty_o = !out_v_q;
  assign out_o   = out_q;

endmodule

/* hdl/q16_fixed_point_alu.sv */
// Top level of the Q16.16 arithmetic unit.
// Depends on q16_pkg, q16_front, q16_fifo and q16_back.
`timescale 1ns / 1ps

// Q16.16 arithmetic unit with queue-style ports. Words are pushed with push_i
// whenever full_o is low; the front end classifies each word (and forms the
// point deltas for a distance) and parks it in a four-entry job queue, so up
// to five words can wait ahead of the execution back end. The back end runs
// one word at a time, through at least its idle and output states, and takes
// the next only when done with the last. Add, subtract and unused commands
// form their result on leaving the queue, multiply goes through the product
// register, a divide takes one quotient bit per cycle over 48 bits in the
// shared divider, a square root of two or more ten Newton steps, each one
// divider pass unless the estimate is zero, and a distance first squares and
// sums its deltas. The divider sets the rate for those commands. Results wait
// in an output word register that the user drains with pop_i while empty_o is
// low; zero_divide is set only for a divide by zero, which returns all ones.
module q16_fixed_point_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  q16_pkg::in_word_t  in_i,
  output logic               empty_o,
  input  logic               pop_i,
  output q16_pkg::out_word_t out_o
);

  logic          fr_valid, fr_ready;
  q16_pkg::job_t fr_job;
  logic          q_valid, q_pop;
  q16_pkg::job_t q_job;

  // Front end: one word per cycle into a holding register while full_o is low.
  q16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_i        (in_i),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready),
    .job_o       (fr_job)
  );

  // Decouples the front end from the long divide and root sequences.
  q16_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_job),
    .rd_valid_o (q_valid),
    .rd_i       (q_pop),
    .rd_data_o  (q_job)
  );

  // Back end: executes jobs and owns the output word register.
  q16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .job_i       (q_job),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_o       (out_o)
  );

endmodule

/* hdl/q16_alu_checker.sv */
// Port-level checker for the Q16.16 arithmetic unit, bound to the top level.
// Depends on q16_pkg and q16_fixed_point_alu_macros.svh.
`timescale 1ns / 1ps
`include "q16_fixed_point_alu_macros.svh"

module q16_alu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full_o,
  input logic               empty_o,
  input logic               pop_i,
  input q16_pkg::out_word_t out_o
);

  // A flagged divide always carries the all-ones value.
  `Q16_ASSERT_IMP(a_zdiv_ones, clk_i, rst_ni, !empty_o && out_o.zero_divide, &out_o.value)
  // A waiting word is not dropped before it is popped.
  `Q16_ASSERT_NXT(a_hold, clk_i, rst_ni, !empty_o && !pop_i, !empty_o)
  // Coming out of reset, nothing is waiting and input is open.
  `Q16_ASSERT_ALL(a_reset, clk_i, !$past(rst_ni) |-> (empty_o && !full_o))
  // Input cannot fill up in the first cycle after reset.
  `Q16_ASSERT_IMP(a_not_full, clk_i, rst_ni, $rose(rst_ni), !full_o)

endmodule

bind q16_fixed_point_alu q16_alu_checker u_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .full_o  (full_o),
  .empty_o (empty_o),
  .pop_i   (pop_i),
  .out_o   (out_o)
);

/* dv/tb.sv */
// Self-checking testbench for the Q16.16 arithmetic unit (q16_fixed_point_alu).
// Depends on q16_pkg and the RTL of the block; drives directed and random words.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STALL_LIMIT = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               push_i;
  logic               full_o;
  q16_pkg::in_word_t  in_i;
  logic               empty_o;
  logic               pop_i;
  q16_pkg::out_word_t out_o;

  q16_fixed_point_alu i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .in_i    (in_i),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .out_o   (out_o)
  );

  // Expected result words, oldest first.
  q16_pkg::out_word_t expected_results[$];
  int        error_count;
  int        idle_cycles;
  // Idle percentages of the sender and receiver for the current phase.
  int        push_idle_pct;
  int        pop_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Signed product, shifted right by the fraction width, low word kept.
  function automatic logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] prod;
    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return prod[q16_pkg::FRAC_BITS +: 32];
  endfunction

  // Unsigned long division; the caller keeps the divisor nonzero.
  function automatic logic [31:0] q_div(logic [31:0] a, logic [31:0] b);
    logic [63:0] num;
    logic [63:0] quo;
    num = {32'd0, a} << q16_pkg::FRAC_BITS;
    quo = num / {32'd0, b};
    return quo[31:0];
  endfunction

  // Newton iteration from half the argument, with a wrapping add.
  function automatic logic [31:0] q_sqrt(logic [31:0] a);
    logic [31:0] x;
    logic [31:0] q;
    logic [31:0] s;
    if (a < 32'd2) return 32'd0;
    x = a >> 1;
    for (int i = 0; i < q16_pkg::ROOT_STEPS; i++) begin
      q = (x == 32'd0) ? 32'hFFFF_FFFF : q_div(a, x);
      s = x + q;
      x = s >> 1;
    end
    return x;
  endfunction

  function automatic q16_pkg::out_word_t alu_result(q16_pkg::in_word_t w);
    q16_pkg::out_word_t r;
    logic [31:0] dx;
    logic [31:0] dy;
    r = '0;
    dx = w.opa - w.opc;
    dy = w.opb - w.opd;
    case (w.cmd)
      q16_pkg::CMD_ADD: r.value = w.opa + w.opb;
      q16_pkg::CMD_SUB: r.value = w.opa - w.opb;
      q16_pkg::CMD_MUL: r.value = q_mul(w.opa, w.opb);
      q16_pkg::CMD_DIV: begin
        if (w.opb == 32'd0) begin
          r.value = 32'hFFFF_FFFF;
          r.zero_divide = 1'b1;
        end else begin
          r.value = q_div(w.opa, w.opb);
        end
      end
      q16_pkg::CMD_SQRT: r.value = q_sqrt(w.opa);
      q16_pkg::CMD_DIST: r.value = q_sqrt(q_mul(dx, dx) + q_mul(dy, dy));
      default:  r.value = 32'd0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Receiver: pops at random and checks each word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", out_o.value, 32'd0);
        end else begin
          q16_pkg::out_word_t want;
          want = expected_results.pop_front();
          if (out_o.value !== want.value)
            report_mismatch("value", out_o.value, want.value);
          if (out_o.zero_divide !== want.zero_divide)
            report_mismatch("zero_divide", 32'(out_o.zero_divide),
                            32'(want.zero_divide));
        end
      end
      pop_i <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sends one word: optional random idle gaps, then holds push until taken.
  // Push stays high afterwards so the next word can follow with no gap.
  task automatic send_word(q16_pkg::in_word_t w);
    while ($urandom_range(99) < push_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_i   <= w;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    expected_results.push_back(alu_result(w));
  endtask

  // Random operands: mostly small magnitudes so roots and quotients stay
  // interesting, with full-range words mixed in.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $urandom_range(32'h0003_0000);
      2:       return 32'hFFFF_0000 | $urandom_range(16'hFFFF);
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  typedef struct {
    q16_pkg::in_word_t  w;
    logic               typed;     // expectation is written out in the row
    q16_pkg::out_word_t want;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{'{q16_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 32'd0, 32'd0},
      1'b1, '{32'h0, 1'b0}},
    '{'{q16_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
        32'hFFFF_FFFF}, 1'b0, '0},
    '{'{q16_pkg::CMD_SUB, 32'h0000_0000, 32'h0000_0001, 32'd0, 32'd0},
      1'b1, '{32'hFFFF_FFFF, 1'b0}},
    '{'{q16_pkg::CMD_SUB, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_MUL, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0},
      1'b1, '{32'h0001_0000, 1'b0}},
    '{'{q16_pkg::CMD_MUL, 32'hFFFF_0000, 32'h0002_0000, 32'd0, 32'd0},
      1'b1, '{32'hFFFE_0000, 1'b0}},
    '{'{q16_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_DIV, 32'h1234_5678, 32'h0000_0000, 32'd0, 32'd0},
      1'b1, '{32'hFFFF_FFFF, 1'b1}},
    '{'{q16_pkg::CMD_DIV, 32'h0000_0000, 32'h0000_0000, 32'd0, 32'd0},
      1'b1, '{32'hFFFF_FFFF, 1'b1}},
    '{'{q16_pkg::CMD_DIV, 32'h0004_0000, 32'h0002_0000, 32'd0, 32'd0},
      1'b1, '{32'h0002_0000, 1'b0}},
    '{'{q16_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_SQRT, 32'h0000_0000, 32'd0, 32'd0, 32'd0}, 1'b1, '{32'h0, 1'b0}},
    '{'{q16_pkg::CMD_SQRT, 32'h0000_0001, 32'd0, 32'd0, 32'd0}, 1'b1, '{32'h0, 1'b0}},
    '{'{q16_pkg::CMD_SQRT, 32'h0000_0002, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_SQRT, 32'h0004_0000, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_SQRT, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_DIST, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'd0}, 1'b0, '0},
    '{'{q16_pkg::CMD_DIST, 32'h1234_0000, 32'h0, 32'h1234_0000, 32'h0},
      1'b1, '{32'h0, 1'b0}},
    '{'{q16_pkg::CMD_DIST, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1'b1, '{32'h0, 1'b0}},
    '{'{3'd7, 32'h1, 32'h0, 32'h0, 32'h0}, 1'b1, '{32'h0, 1'b0}}
  };

  initial begin
    q16_pkg::in_word_t w;
    int                wait_cycles;
    rst_ni        = 1'b0;
    push_i        = 1'b0;
    pop_i         = 1'b0;
    in_i          = '0;
    error_count   = 0;
    idle_cycles   = 0;
    push_idle_pct = 0;
    pop_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: typed expectations are checked against the predictor
    // first, so a slip in the table shows up as its own error.
    foreach (directed[i]) begin
      if (directed[i].typed && alu_result(directed[i].w) !== directed[i].want)
        report_mismatch("directed row", alu_result(directed[i].w).value,
                        directed[i].want.value);
      send_word(directed[i].w);
    end

    // Random words in four idling phases: none, sender idle, receiver
    // stalling, both.
    for (int n = 0; n < 500; n++) begin
      case (n / 125)
        0: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin push_idle_pct = 57; pop_stall_pct = 0;  end
        2: begin push_idle_pct = 0;  pop_stall_pct = 57; end
        default: begin push_idle_pct = 17; pop_stall_pct = 17; end
      endcase
      w.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      w.opa = rand_operand();
      w.opb = ($urandom_range(15) == 0) ? 32'd0 : rand_operand();
      w.opc = rand_operand();
      w.opd = rand_operand();
      send_word(w);
    end
    push_i <= 1'b0;

    pop_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // Let a stray late word show up before judging.
    wait_cycles = 0;
    while (wait_cycles < 600) begin
      @(posedge clk_i);
      wait_cycles++;
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/q16_pkg.sv
hdl/q16_front.sv
hdl/q16_fifo.sv
hdl/q16_back.sv
hdl/q16_fixed_point_alu.sv
hdl/q16_alu_checker.sv
dv/tb.sv
